// ----- src/mbe_pkg.sv -----
package mbe_pkg;

	// Field and register widths
	localparam int COORD_BITS = 10;
	localparam int FRAC_BITS  = 28;
	localparam int PIXEL_W    = 10;
	localparam int COUNT_W    = 16;
	localparam int STEP_W     = 29;
	localparam int ORIGIN_W   = 32;
	localparam int CFG_DATA_W = 32;
	localparam int CFG_IDX_W  = 2;

	// Coordinate product and point width
	localparam int PROD_W = COORD_BITS + STEP_W;
	localparam int C_W    = ((PROD_W > ORIGIN_W) ? PROD_W : ORIGIN_W) + 1;

	// Iteration datapath widths: magnitudes below 2.0, squares, cross term, z
	localparam int MAG_W = FRAC_BITS + 1;
	localparam int SQP_W = 2 * MAG_W;
	localparam int SQ_W  = SQP_W - FRAC_BITS;
	localparam int CR_W  = SQP_W - FRAC_BITS + 1;
	localparam int Z_W   = ((C_W > CR_W) ? C_W : CR_W) + 2;

	// Job queue between front and back
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_RE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_IM = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_STEP_SIZE = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ITER_LIM  = 2'd3;

	// Reset values of the configuration registers
	localparam logic signed [ORIGIN_W-1:0] ORIGIN_RE_RST = -32'sd671088640;
	localparam logic signed [ORIGIN_W-1:0] ORIGIN_IM_RST = -32'sd536870912;
	localparam logic [STEP_W-1:0]          STEP_RST      = 29'd1048576;
	localparam logic [COUNT_W-1:0]         ITER_LIM_RST  = 16'd100;

	// One pixel ready for iteration
	typedef struct packed {
		logic signed [C_W-1:0] c_re;
		logic signed [C_W-1:0] c_im;
		logic [COUNT_W-1:0]    count;
	} mbe_job_t;

	typedef enum logic [1:0] {
		B_IDLE,
		B_MUL,
		B_ADD,
		B_DONE
	} mbe_back_state_t;

endpackage

// ----- src/mandelbrot_escape_time.sv -----
// Mandelbrot escape-time counter. Each request carries a pixel column, a pixel
// row and a starting count; the block forms c = origin + coordinate * step in
// Q12.28, iterates z = z*z + c from zero while |z|^2 < 4 and the count is below
// iteration_limit, and returns the final count. A front stage scales the
// pixel into c and hands it through a two-entry queue to the iteration engine,
// so the next pixel is staged while the current one iterates. The engine
// spends a multiply state (three 29x29 products registered) and then an add
// state (the add and escape test) on each iteration, and takes the next pixel
// only once the current result is loaded, so a stall on the output also holds
// the loop. The user must see that configuration registers are written only
// while no request is in flight; the block itself does not enforce this.
module mandelbrot_escape_time (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic [mbe_pkg::PIXEL_W-1:0]        pixel_col,
	input  logic [mbe_pkg::PIXEL_W-1:0]        pixel_row,
	input  logic [mbe_pkg::COUNT_W-1:0]        start_count,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic [mbe_pkg::COUNT_W-1:0]        escape_count,
	input  logic                               cfg_wr_en,
	input  logic [mbe_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [mbe_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
	import mbe_pkg::*;

	logic signed [ORIGIN_W-1:0]  origin_re_q;
	logic signed [ORIGIN_W-1:0]  origin_im_q;
	logic [STEP_W-1:0]           step_size_q;
	logic [COUNT_W-1:0]          iter_lim_q;

	logic      q_full;
	logic      q_empty;
	logic      q_push;
	logic      q_pop;
	mbe_job_t  push_job;
	mbe_job_t  head_job;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_re_q <= ORIGIN_RE_RST;
			origin_im_q <= ORIGIN_IM_RST;
			step_size_q <= STEP_RST;
			iter_lim_q  <= ITER_LIM_RST;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_ORIGIN_RE: origin_re_q <= signed'(cfg_wdata[ORIGIN_W-1:0]);
				REG_ORIGIN_IM: origin_im_q <= signed'(cfg_wdata[ORIGIN_W-1:0]);
				REG_STEP_SIZE: step_size_q <= cfg_wdata[STEP_W-1:0];
				REG_ITER_LIM:  iter_lim_q  <= cfg_wdata[COUNT_W-1:0];
			endcase
		end
	end

	mbe_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.pixel_col   (pixel_col),
		.pixel_row   (pixel_row),
		.start_count (start_count),
		.origin_re   (origin_re_q),
		.origin_im   (origin_im_q),
		.step_size   (step_size_q),
		.q_full      (q_full),
		.q_push      (q_push),
		.q_job       (push_job)
	);

	mbe_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_job (push_job),
		.pop      (q_pop),
		.head_job (head_job),
		.full     (q_full),
		.empty    (q_empty)
	);

	mbe_back u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.iteration_limit (iter_lim_q),
		.head_job        (head_job),
		.q_empty         (q_empty),
		.q_pop           (q_pop),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.escape_count    (escape_count)
	);

endmodule

// ----- src/mbe_front.sv -----
module mbe_front (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic [mbe_pkg::PIXEL_W-1:0]           pixel_col,
	input  logic [mbe_pkg::PIXEL_W-1:0]           pixel_row,
	input  logic [mbe_pkg::COUNT_W-1:0]           start_count,
	input  logic signed [mbe_pkg::ORIGIN_W-1:0]   origin_re,
	input  logic signed [mbe_pkg::ORIGIN_W-1:0]   origin_im,
	input  logic [mbe_pkg::STEP_W-1:0]            step_size,
	input  logic                                  q_full,
	output logic                                  q_push,
	output mbe_pkg::mbe_job_t                     q_job
);
	import mbe_pkg::*;

	logic                  valid_s1;
	logic [PROD_W-1:0]     prod_re_s1;
	logic [PROD_W-1:0]     prod_im_s1;
	logic [COUNT_W-1:0]    count_s1;
	logic                  accept;

	// Hold the request while the staged one cannot enter the queue
	assign in_stall = valid_s1 && q_full;
	assign accept   = in_valid && !in_stall;
	assign q_push   = valid_s1 && !q_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (q_push) begin
			valid_s1 <= 1'b0;
		end
	end

	// Scale the masked pixel coordinates by the step
	always_ff @(posedge clk) begin
		if (accept) begin
			prod_re_s1 <= PROD_W'(pixel_col[COORD_BITS-1:0]) * PROD_W'(step_size);
			prod_im_s1 <= PROD_W'(pixel_row[COORD_BITS-1:0]) * PROD_W'(step_size);
			count_s1   <= start_count;
		end
	end

	// Offset by the origin to form c
	always_comb begin
		q_job.c_re  = C_W'(origin_re) + signed'(C_W'(prod_re_s1));
		q_job.c_im  = C_W'(origin_im) + signed'(C_W'(prod_im_s1));
		q_job.count = count_s1;
	end

endmodule

// ----- src/mbe_queue.sv -----
module mbe_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  mbe_pkg::mbe_job_t push_job,
	input  logic              pop,
	output mbe_pkg::mbe_job_t head_job,
	output logic              full,
	output logic              empty
);
	import mbe_pkg::*;

	mbe_job_t            entry_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q;
	logic [QPTR_W-1:0]   rd_ptr_q;
	logic [QCNT_W-1:0]   fill_q;

	assign full     = (fill_q == QCNT_W'(QUEUE_DEPTH));
	assign empty    = (fill_q == '0);
	assign head_job = entry_q[rd_ptr_q];

	// Advance pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (pop && !push) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_job;
		end
	end

`ifndef ASSERT_OFF
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (!full || pop))
		else $error("queue written while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty)
		else $error("queue read while empty");
`endif

endmodule

// ----- src/mbe_back.sv -----
module mbe_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [mbe_pkg::COUNT_W-1:0]   iteration_limit,
	input  mbe_pkg::mbe_job_t             head_job,
	input  logic                          q_empty,
	output logic                          q_pop,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [mbe_pkg::COUNT_W-1:0]   escape_count
);
	import mbe_pkg::*;

	mbe_back_state_t         state_q;
	mbe_back_state_t         state_d;

	logic signed [Z_W-1:0]   zr_q;
	logic signed [Z_W-1:0]   zi_q;
	logic signed [C_W-1:0]   c_re_q;
	logic signed [C_W-1:0]   c_im_q;
	logic [COUNT_W-1:0]      count_q;
	logic                    out_valid_q;
	logic [COUNT_W-1:0]      escape_count_q;

	logic [SQP_W-1:0]        prod_rr_s1;
	logic [SQP_W-1:0]        prod_ii_s1;
	logic [SQP_W-1:0]        prod_ri_s1;
	logic                    neg_s1;

	logic [Z_W-1:0]          mag_r;
	logic [Z_W-1:0]          mag_i;
	logic                    mul_exit;
	logic [SQ_W-1:0]         sq_r;
	logic [SQ_W-1:0]         sq_i;
	logic [SQ_W:0]           sq_sum;
	logic                    add_exit;
	logic [CR_W-1:0]         cross_mag;
	logic                    cross_rem;
	logic signed [Z_W-1:0]   cross_term;
	logic signed [Z_W-1:0]   zr_next;
	logic signed [Z_W-1:0]   zi_next;
	logic                    load_out;

	// Multiply stage: magnitudes, the iteration limit test and the bound test on |zr|, |zi|
	always_comb begin
		mag_r    = zr_q[Z_W-1] ? Z_W'(-zr_q) : Z_W'(zr_q);
		mag_i    = zi_q[Z_W-1] ? Z_W'(-zi_q) : Z_W'(zi_q);
		mul_exit = (count_q >= iteration_limit) || (|mag_r[Z_W-1:MAG_W])
			|| (|mag_i[Z_W-1:MAG_W]);
	end

	// Add stage: squares, escape test on |z|^2 and the floored cross term
	always_comb begin
		sq_r      = prod_rr_s1[SQP_W-1:FRAC_BITS];
		sq_i      = prod_ii_s1[SQP_W-1:FRAC_BITS];
		sq_sum    = {1'b0, sq_r} + {1'b0, sq_i};
		add_exit  = sq_sum[SQ_W];
		cross_mag = prod_ri_s1[SQP_W-1:FRAC_BITS-1];
		cross_rem = |prod_ri_s1[FRAC_BITS-2:0];
		if (neg_s1) begin
			cross_term = -(signed'(Z_W'(cross_mag)) + signed'(Z_W'(cross_rem)));
		end else begin
			cross_term = signed'(Z_W'(cross_mag));
		end
		zr_next = signed'(Z_W'(sq_r)) - signed'(Z_W'(sq_i)) + Z_W'(c_re_q);
		zi_next = cross_term + Z_W'(c_im_q);
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			B_IDLE: begin
				if (!q_empty) begin
					state_d = B_MUL;
				end
			end
			B_MUL: begin
				state_d = mul_exit ? B_DONE : B_ADD;
			end
			B_ADD: begin
				state_d = add_exit ? B_DONE : B_MUL;
			end
			B_DONE: begin
				if (!out_valid_q || !out_stall) begin
					state_d = B_IDLE;
				end
			end
		endcase
	end

	// Outputs of the sequencer
	always_comb begin
		q_pop    = (state_q == B_IDLE) && !q_empty;
		load_out = (state_q == B_DONE) && (!out_valid_q || !out_stall);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Iteration datapath
	always_ff @(posedge clk) begin
		if (q_pop) begin
			zr_q    <= '0;
			zi_q    <= '0;
			c_re_q  <= head_job.c_re;
			c_im_q  <= head_job.c_im;
			count_q <= head_job.count;
		end
		if (state_q == B_MUL) begin
			prod_rr_s1 <= SQP_W'(mag_r[MAG_W-1:0]) * SQP_W'(mag_r[MAG_W-1:0]);
			prod_ii_s1 <= SQP_W'(mag_i[MAG_W-1:0]) * SQP_W'(mag_i[MAG_W-1:0]);
			prod_ri_s1 <= SQP_W'(mag_r[MAG_W-1:0]) * SQP_W'(mag_i[MAG_W-1:0]);
			neg_s1     <= zr_q[Z_W-1] ^ zi_q[Z_W-1];
		end
		if ((state_q == B_ADD) && !add_exit) begin
			zr_q    <= zr_next;
			zi_q    <= zi_next;
			count_q <= count_q + COUNT_W'(1);
		end
		if (load_out) begin
			escape_count_q <= count_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign escape_count = escape_count_q;

`ifndef ASSERT_OFF
	a_add_after_mul: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == B_ADD) |-> ($past(state_q) == B_MUL))
		else $error("add stage entered without a multiply stage");

	a_count_below_limit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == B_ADD) |-> (count_q < iteration_limit))
		else $error("iteration past the limit");

	a_result_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		load_out |=> (out_valid_q && (escape_count_q == $past(count_q))))
		else $error("finished count not presented");
`endif

endmodule
